>>> rtl/lcsp_pkg.sv
// Shared types, command codes and the command decoder for the LCD command stream parser.
package lcsp_pkg;

    // Stream escape byte and command codes
    localparam logic [7:0] ESC_BYTE       = 8'd254;
    localparam logic [7:0] CMD_BL_ON      = 8'd66;
    localparam logic [7:0] CMD_BL_OFF     = 8'd70;
    localparam logic [7:0] CMD_CLEAR      = 8'd88;
    localparam logic [7:0] CMD_HOME       = 8'd72;
    localparam logic [7:0] CMD_POSITION   = 8'd71;
    localparam logic [7:0] CMD_UL_ON      = 8'd74;
    localparam logic [7:0] CMD_UL_OFF     = 8'd75;
    localparam logic [7:0] CMD_BLINK_ON   = 8'd83;
    localparam logic [7:0] CMD_BLINK_OFF  = 8'd84;
    localparam logic [7:0] CMD_BRIGHTNESS = 8'd152;
    localparam logic [7:0] CMD_CUSTOM     = 8'd78;
    localparam logic [7:0] CMD_EXIT       = 8'd154;

    // Parameter byte counts
    localparam logic [3:0] NPARAM_BL_ON   = 4'd1;
    localparam logic [3:0] NPARAM_POS     = 4'd2;
    localparam logic [3:0] NPARAM_BRIGHT  = 4'd1;
    localparam logic [3:0] NPARAM_CUSTOM  = 4'd9;

    // Custom character: address byte plus eight bitmap rows
    localparam int CG_BYTES = 9;

    // Host status codes
    localparam logic [1:0] HS_NONE    = 2'd0;
    localparam logic [1:0] HS_STOP    = 2'd1;
    localparam logic [1:0] HS_RESTART = 2'd2;

    // Display operation codes
    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_CHAR       = 4'd1,
        OP_BACKLIGHT  = 4'd2,
        OP_CLEAR      = 4'd3,
        OP_HOME       = 4'd4,
        OP_CURSOR_POS = 4'd5,
        OP_UNDERLINE  = 4'd6,
        OP_BLINK      = 4'd7,
        OP_CGRAM_ADDR = 4'd8,
        OP_RAM_DATA   = 4'd9
    } disp_op_t;

    // What to do once all parameter bytes are in
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_POS,
        PEND_CUSTOM
    } pend_t;

    // Controller states (parse mode plus result sequencing)
    typedef enum logic [2:0] {
        ST_TEXT,
        ST_CMD,
        ST_PARAMS,
        ST_POS_MUL,
        ST_POS_OUT,
        ST_CG_RD,
        ST_CG_OUT
    } state_t;

    // Output register source select
    typedef enum logic [1:0] {
        OSEL_CHAR,
        OSEL_CMD,
        OSEL_POS,
        OSEL_CG
    } out_sel_t;

    // Decoded command byte
    typedef struct packed {
        logic       emit;
        disp_op_t   op;
        logic [7:0] value;
        logic [1:0] status;
        logic       wait_params;
        logic [3:0] needed;
        pend_t      pend;
    } cmd_info_t;

    // Controller -> datapath
    typedef struct packed {
        logic     load_out;
        out_sel_t out_sel;
        logic     load_cmd;
        logic     load_param;
        logic     mult_en;
        logic     idx_clr;
        logic     idx_inc;
        logic     cg_read;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic      is_escape;
        cmd_info_t info;
        logic      params_done;
        pend_t     pend;
        logic      idx_last;
        logic      out_free;
    } dp_stat_t;

    // Command byte decoder
    function automatic cmd_info_t decode_cmd(input logic [7:0] cmd_byte);
        cmd_info_t info;
        info.emit        = 1'b0;
        info.op          = OP_NONE;
        info.value       = 8'd0;
        info.status      = HS_NONE;
        info.wait_params = 1'b0;
        info.needed      = 4'd0;
        info.pend        = PEND_NONE;
        unique case (cmd_byte)
            CMD_BL_ON: begin
                info.emit        = 1'b1;
                info.op          = OP_BACKLIGHT;
                info.value       = 8'd1;
                info.wait_params = 1'b1;
                info.needed      = NPARAM_BL_ON;
            end
            CMD_BL_OFF: begin
                info.emit = 1'b1;
                info.op   = OP_BACKLIGHT;
            end
            CMD_CLEAR: begin
                info.emit = 1'b1;
                info.op   = OP_CLEAR;
            end
            CMD_HOME: begin
                info.emit = 1'b1;
                info.op   = OP_HOME;
            end
            CMD_POSITION: begin
                info.wait_params = 1'b1;
                info.needed      = NPARAM_POS;
                info.pend        = PEND_POS;
            end
            CMD_UL_ON: begin
                info.emit  = 1'b1;
                info.op    = OP_UNDERLINE;
                info.value = 8'd1;
            end
            CMD_UL_OFF: begin
                info.emit = 1'b1;
                info.op   = OP_UNDERLINE;
            end
            CMD_BLINK_ON: begin
                info.emit  = 1'b1;
                info.op    = OP_BLINK;
                info.value = 8'd1;
            end
            CMD_BLINK_OFF: begin
                info.emit = 1'b1;
                info.op   = OP_BLINK;
            end
            CMD_BRIGHTNESS: begin
                info.wait_params = 1'b1;
                info.needed      = NPARAM_BRIGHT;
            end
            CMD_CUSTOM: begin
                info.wait_params = 1'b1;
                info.needed      = NPARAM_CUSTOM;
                info.pend        = PEND_CUSTOM;
            end
            CMD_EXIT: begin
                info.emit   = 1'b1;
                info.status = HS_RESTART;
            end
            // unknown commands are dropped
            default: info.emit = 1'b0;
        endcase
        return info;
    endfunction

endpackage

>>> rtl/lcsp_ctrl.sv
// Controller state machine: parse mode tracking and result sequencing.
module lcsp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lcsp_pkg::dp_stat_t   stat,
    output lcsp_pkg::ctrl_cmd_t  ctrl
);

    lcsp_pkg::state_t state_reg;
    lcsp_pkg::state_t state_next;
    logic             accept;

    // Input beats are taken only in the parse states, and only with room at the output
    always_comb begin
        unique case (state_reg)
            lcsp_pkg::ST_TEXT,
            lcsp_pkg::ST_CMD,
            lcsp_pkg::ST_PARAMS: s_tready = stat.out_free;
            default:             s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcsp_pkg::ST_TEXT: begin
                if (accept && stat.is_escape) state_next = lcsp_pkg::ST_CMD;
            end
            lcsp_pkg::ST_CMD: begin
                if (accept) begin
                    state_next = stat.info.wait_params ? lcsp_pkg::ST_PARAMS
                                                       : lcsp_pkg::ST_TEXT;
                end
            end
            lcsp_pkg::ST_PARAMS: begin
                if (accept && stat.params_done) begin
                    case (stat.pend)
                        lcsp_pkg::PEND_POS:    state_next = lcsp_pkg::ST_POS_MUL;
                        lcsp_pkg::PEND_CUSTOM: state_next = lcsp_pkg::ST_CG_RD;
                        default:               state_next = lcsp_pkg::ST_TEXT;
                    endcase
                end
            end
            lcsp_pkg::ST_POS_MUL: state_next = lcsp_pkg::ST_POS_OUT;
            lcsp_pkg::ST_POS_OUT: begin
                if (stat.out_free) state_next = lcsp_pkg::ST_TEXT;
            end
            lcsp_pkg::ST_CG_RD: state_next = lcsp_pkg::ST_CG_OUT;
            lcsp_pkg::ST_CG_OUT: begin
                if (stat.out_free) begin
                    state_next = stat.idx_last ? lcsp_pkg::ST_TEXT : lcsp_pkg::ST_CG_RD;
                end
            end
            default: state_next = lcsp_pkg::ST_TEXT;
        endcase
    end

    // Datapath commands
    always_comb begin
        ctrl = '0;
        ctrl.out_sel = lcsp_pkg::OSEL_CHAR;
        unique case (state_reg)
            lcsp_pkg::ST_TEXT: begin
                ctrl.load_out = accept && !stat.is_escape;
                ctrl.out_sel  = lcsp_pkg::OSEL_CHAR;
            end
            lcsp_pkg::ST_CMD: begin
                ctrl.load_out = accept && stat.info.emit;
                ctrl.out_sel  = lcsp_pkg::OSEL_CMD;
                ctrl.load_cmd = accept && stat.info.wait_params;
            end
            lcsp_pkg::ST_PARAMS: begin
                ctrl.load_param = accept;
                ctrl.idx_clr    = accept;
            end
            lcsp_pkg::ST_POS_MUL: begin
                ctrl.mult_en = 1'b1;
            end
            lcsp_pkg::ST_POS_OUT: begin
                ctrl.load_out = stat.out_free;
                ctrl.out_sel  = lcsp_pkg::OSEL_POS;
            end
            lcsp_pkg::ST_CG_RD: begin
                ctrl.cg_read = 1'b1;
            end
            lcsp_pkg::ST_CG_OUT: begin
                ctrl.cg_read  = 1'b1;
                ctrl.load_out = stat.out_free;
                ctrl.out_sel  = lcsp_pkg::OSEL_CG;
                ctrl.idx_inc  = stat.out_free;
            end
            default: ctrl.load_out = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lcsp_pkg::ST_TEXT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/lcsp_datapath.sv
// Datapath: config register, parameter store, cursor address math and output register.
module lcsp_datapath #(
    parameter int PARAM_SLOTS = 9
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [5:0]           cfg_wr_data,
    input  logic [7:0]           rx_byte,
    input  lcsp_pkg::ctrl_cmd_t  ctrl,
    output lcsp_pkg::dp_stat_t   stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [3:0]           out_op,
    output logic [7:0]           out_value,
    output logic [1:0]           out_status,
    output logic                 out_last
);

    localparam int SLOT_W = $clog2(PARAM_SLOTS);

    // Control state
    logic [5:0]            cols_reg;
    lcsp_pkg::pend_t       pend_reg;
    logic [3:0]            needed_reg;
    logic [3:0]            rcvd_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic                  out_valid_reg;

    // Payload
    logic [7:0]            param_mem [PARAM_SLOTS];
    logic [7:0]            rd_data_reg;
    logic [7:0]            row_reg;
    logic [7:0]            prod_reg;
    lcsp_pkg::disp_op_t    op_reg;
    logic [7:0]            value_reg;
    logic [1:0]            status_reg;
    logic                  last_reg;

    logic [3:0]            rcvd_inc;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     rd_addr;
    logic [7:0]            row_m1;
    logic [7:0]            pos_addr;
    logic                  out_free;
    lcsp_pkg::cmd_info_t   info;

    lcsp_pkg::disp_op_t    op_next;
    logic [7:0]            value_next;
    logic [1:0]            status_next;
    logic                  last_next;

    assign info     = lcsp_pkg::decode_cmd(rx_byte);
    assign rcvd_inc = rcvd_reg + 4'd1;
    assign slot_ok  = 32'(rcvd_reg) < PARAM_SLOTS;
    assign rd_addr  = ctrl.cg_read ? idx_reg : '0;
    assign row_m1   = row_reg - 8'd1;
    assign pos_addr = prod_reg + rd_data_reg;
    assign out_free = !out_valid_reg || out_ready;

    // Status to the controller
    always_comb begin
        stat.is_escape   = (rx_byte == lcsp_pkg::ESC_BYTE);
        stat.info        = info;
        stat.params_done = (rcvd_inc >= needed_reg);
        stat.pend        = pend_reg;
        stat.idx_last    = (idx_reg == SLOT_W'(lcsp_pkg::CG_BYTES - 1));
        stat.out_free    = out_free;
    end

    // Config register and command bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg   <= 6'd20;
            pend_reg   <= lcsp_pkg::PEND_NONE;
            needed_reg <= 4'd0;
            rcvd_reg   <= 4'd0;
            idx_reg    <= '0;
        end else begin
            if (cfg_wr_en) cols_reg <= cfg_wr_data;
            if (ctrl.load_cmd) begin
                pend_reg   <= info.pend;
                needed_reg <= info.needed;
                rcvd_reg   <= 4'd0;
            end else if (ctrl.load_param) begin
                rcvd_reg <= rcvd_inc;
            end
            if (ctrl.idx_clr) begin
                idx_reg <= '0;
            end else if (ctrl.idx_inc) begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
    end

    // Parameter store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.load_param && slot_ok) param_mem[rcvd_reg[SLOT_W-1:0]] <= rx_byte;
        rd_data_reg <= param_mem[rd_addr];
    end

    // Cursor address: (row - 1) * columns, registered before the column add
    always_ff @(posedge aclk) begin
        if (ctrl.load_param) row_reg <= rx_byte;
        if (ctrl.mult_en) prod_reg <= 8'(row_m1 * {2'b00, cols_reg});
    end

    // Output source select
    always_comb begin
        case (ctrl.out_sel)
            lcsp_pkg::OSEL_CHAR: begin
                op_next     = lcsp_pkg::OP_CHAR;
                value_next  = rx_byte;
                status_next = lcsp_pkg::HS_NONE;
                last_next   = 1'b1;
            end
            lcsp_pkg::OSEL_CMD: begin
                op_next     = info.op;
                value_next  = info.value;
                status_next = info.status;
                last_next   = 1'b1;
            end
            lcsp_pkg::OSEL_POS: begin
                op_next     = lcsp_pkg::OP_CURSOR_POS;
                value_next  = pos_addr;
                status_next = (pos_addr == 8'd1) ? lcsp_pkg::HS_STOP : lcsp_pkg::HS_NONE;
                last_next   = 1'b1;
            end
            default: begin
                op_next     = (idx_reg == '0) ? lcsp_pkg::OP_CGRAM_ADDR
                                              : lcsp_pkg::OP_RAM_DATA;
                value_next  = rd_data_reg;
                status_next = lcsp_pkg::HS_NONE;
                last_next   = stat.idx_last;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            op_reg     <= op_next;
            value_reg  <= value_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_op     = op_reg;
    assign out_value  = value_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

endmodule

>>> rtl/lcd_command_stream_parser.sv
// Top level of the serial LCD command stream parser.
//
//  Channel  Dir  Ports                       Contents
//  s_       in   tvalid/tready/tdata[7:0]    rx_byte
//  m_       out  tvalid/tready/tdata[15:0]   op_value, host_status
//                tuser[3:0], tlast           display_op, last_of_run
//  cfg_     in   wr_en, wr_data[5:0]         columns_per_row
//
// Text and simple commands: one beat per cycle unless stalled, result in the next cycle.
// Position: the last parameter beat is followed by a multiply stage, then the add.
// Custom character: 9 result beats, each a parameter store read, then an output load.
// s_tready is low while position or custom-character results are produced, and whenever
// the output register holds a beat that m_tready does not take.
// Reset is synchronous, active low; no clearing pass is needed.
module lcd_command_stream_parser #(
    parameter int PARAM_SLOTS = 9
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,     // columns_per_row
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,         // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,         // [7:0] op_value, [9:8] host_status, rest zero
    output logic [3:0]  m_tuser,         // [3:0] display_op
    output logic        m_tlast          // last_of_run
);

    lcsp_pkg::ctrl_cmd_t ctrl;
    lcsp_pkg::dp_stat_t  stat;
    logic [7:0]          op_value;
    logic [1:0]          host_status;

    lcsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    lcsp_datapath #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx_byte     (s_tdata),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_op      (m_tuser),
        .out_value   (op_value),
        .out_status  (host_status),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, host_status, op_value};

endmodule

>>> rtl/lcsp_checker.sv
// Port-level checker for the LCD command stream parser, bound to the top level.
module lcsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // Output beat is dropped by reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output beat changed");

    // Only defined display operations appear
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 4'd9) && (m_tdata[15:10] == 6'd0))
        else $error("undefined display operation or padding set");

    // Host status only on exit or on a cursor address of one
    a_status_src: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[9:8] != 2'd0) |->
            (m_tuser == 4'd0 && m_tdata[9:8] == 2'd2 && m_tdata[7:0] == 8'd0) ||
            (m_tuser == 4'd5 && m_tdata[9:8] == 2'd1 && m_tdata[7:0] == 8'd1))
        else $error("host status on unexpected operation");

    // Everything but the custom-character address and bitmap rows closes its run
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != 4'd8) && (m_tuser != 4'd9) |-> m_tlast)
        else $error("single-result beat without tlast");

endmodule

bind lcd_command_stream_parser lcsp_checker u_lcsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> dv/lcd_command_stream_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LCD command stream parser: byte stream in, display ops out.
module lcd_command_stream_parser_test;
    import lcsp_pkg::*;

    // Codes the package does not name
    localparam logic [7:0] CMD_NET_INFO  = 8'd153;
    localparam logic [7:0] CMD_UNDEFINED = 8'd0;

    localparam int RANDOM_PER_PHASE = 45;
    localparam int SETTLE_CYCLES    = 24;
    localparam int MAX_REPORTS      = 10;

    typedef enum logic [1:0] {
        RX_TEXT,
        RX_CMD,
        RX_ARGS
    } rx_mode_t;

    // One expected result beat
    typedef struct packed {
        disp_op_t   op;
        logic [7:0] value;
        logic [1:0] status;
        logic       last;
    } display_beat_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = 6'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // Bytes waiting to be sent and display ops waiting to come out
    logic [7:0]    rx_backlog[$];
    display_beat_t pending_display_ops[$];
    int            mismatches = 0;

    // Parser shadow state
    rx_mode_t   rx_mode     = RX_TEXT;
    logic [7:0] cmd_code    = 8'd0;
    logic [3:0] args_needed = 4'd0;
    logic [3:0] args_seen   = 4'd0;
    logic [7:0] arg_buf [0:CG_BYTES-1];
    logic [5:0] row_stride  = 6'd20;

    // Sender burst/gap pacing
    int burst_left = 1;
    int gap_left   = 0;

    // Receiver stall pattern
    int         stall_mode = 0;
    int         stall_left = 0;
    logic [7:0] stall_tick = 8'd0;
    logic       ready_next;

    lcd_command_stream_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Enter parameter collection for a command
    task automatic await_args(input logic [7:0] code, input logic [3:0] count);
        rx_mode     = RX_ARGS;
        cmd_code    = code;
        args_needed = count;
        args_seen   = 4'd0;
    endtask

    // Advance the shadow parser by one received byte, queue the display ops it causes
    task automatic parse_rx_byte(input logic [7:0] rx);
        display_beat_t batch[$];
        logic [7:0]    addr;
        case (rx_mode)
            RX_CMD: begin
                rx_mode = RX_TEXT;
                case (rx)
                    CMD_BL_ON: begin
                        batch.push_back('{OP_BACKLIGHT, 8'd1, HS_NONE, 1'b0});
                        await_args(rx, NPARAM_BL_ON);
                    end
                    CMD_BL_OFF:     batch.push_back('{OP_BACKLIGHT, 8'd0, HS_NONE, 1'b0});
                    CMD_CLEAR:      batch.push_back('{OP_CLEAR, 8'd0, HS_NONE, 1'b0});
                    CMD_HOME:       batch.push_back('{OP_HOME, 8'd0, HS_NONE, 1'b0});
                    CMD_UL_ON:      batch.push_back('{OP_UNDERLINE, 8'd1, HS_NONE, 1'b0});
                    CMD_UL_OFF:     batch.push_back('{OP_UNDERLINE, 8'd0, HS_NONE, 1'b0});
                    CMD_BLINK_ON:   batch.push_back('{OP_BLINK, 8'd1, HS_NONE, 1'b0});
                    CMD_BLINK_OFF:  batch.push_back('{OP_BLINK, 8'd0, HS_NONE, 1'b0});
                    CMD_EXIT:       batch.push_back('{OP_NONE, 8'd0, HS_RESTART, 1'b0});
                    CMD_POSITION:   await_args(rx, NPARAM_POS);
                    CMD_BRIGHTNESS: await_args(rx, NPARAM_BRIGHT);
                    CMD_CUSTOM:     await_args(rx, NPARAM_CUSTOM);
                    default: ;      // unknown code: dropped
                endcase
            end
            RX_ARGS: begin
                if (args_seen < CG_BYTES) begin
                    arg_buf[args_seen] = rx;
                end
                args_seen = args_seen + 4'd1;
                if (args_seen >= args_needed) begin
                    rx_mode = RX_TEXT;
                    if (cmd_code == CMD_POSITION) begin
                        // (row-1)*stride+col, all mod 256
                        addr = (arg_buf[1] - 8'd1) * {2'b00, row_stride} + arg_buf[0];
                        batch.push_back('{OP_CURSOR_POS, addr,
                                          (addr == 8'd1) ? HS_STOP : HS_NONE, 1'b0});
                    end else if (cmd_code == CMD_CUSTOM) begin
                        batch.push_back('{OP_CGRAM_ADDR, arg_buf[0], HS_NONE, 1'b0});
                        for (int k = 1; k < CG_BYTES; k++) begin
                            batch.push_back('{OP_RAM_DATA, arg_buf[k], HS_NONE, 1'b0});
                        end
                    end
                end
            end
            default: begin
                if (rx == ESC_BYTE) begin
                    rx_mode = RX_CMD;
                end else begin
                    batch.push_back('{OP_CHAR, rx, HS_NONE, 1'b0});
                end
            end
        endcase
        if (batch.size() > 0) begin
            batch[batch.size()-1].last = 1'b1;
        end
        foreach (batch[i]) begin
            pending_display_ops.push_back(batch[i]);
        end
    endtask

    task automatic note_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (mismatches < MAX_REPORTS) begin
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
        mismatches++;
    endtask

    // Driver: sends the backlog in bursts, predicts each accepted beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (rx_backlog.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_backlog.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat, drives its own stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_display_ops.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("unexpected result beat: op %0d value %0d status %0d last %0d",
                                 m_tuser, m_tdata[7:0], m_tdata[9:8], m_tlast);
                    end
                    mismatches++;
                end else begin
                    display_beat_t want;
                    want = pending_display_ops.pop_front();
                    if (m_tuser !== want.op)
                        note_mismatch("display_op", 16'(want.op), 16'(m_tuser));
                    if (m_tdata[7:0] !== want.value)
                        note_mismatch("op_value", 16'(want.value), 16'(m_tdata[7:0]));
                    if (m_tdata[9:8] !== want.status)
                        note_mismatch("host_status", 16'(want.status), 16'(m_tdata[9:8]));
                    if (m_tdata[15:10] !== 6'd0)
                        note_mismatch("tdata padding", 16'd0, 16'(m_tdata[15:10]));
                    if (m_tlast !== want.last)
                        note_mismatch("last_of_run", 16'(want.last), 16'(m_tlast));
                end
            end
            // pick a new stall style now and then
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end else begin
                stall_left--;
            end
            stall_tick = stall_tick + 8'd1;
            case (stall_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = ($urandom_range(0, 3) != 0);
                2:       ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = stall_tick[1];
            endcase
            m_tready <= ready_next;
        end
    end

    task automatic queue_cmd(input logic [7:0] code);
        rx_backlog.push_back(ESC_BYTE);
        rx_backlog.push_back(code);
    endtask

    // Mostly well-formed commands with random content, plus text and noise
    task automatic queue_random_traffic(input int count);
        int queued;
        int pick;
        int n;
        queued = 0;
        while (queued < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                rx_backlog.push_back(8'($urandom_range(0, 253)));
                queued += 1;
            end else if (pick < 44) begin
                case ($urandom_range(0, 7))
                    0:       queue_cmd(CMD_BL_OFF);
                    1:       queue_cmd(CMD_CLEAR);
                    2:       queue_cmd(CMD_HOME);
                    3:       queue_cmd(CMD_UL_ON);
                    4:       queue_cmd(CMD_UL_OFF);
                    5:       queue_cmd(CMD_BLINK_ON);
                    6:       queue_cmd(CMD_BLINK_OFF);
                    default: queue_cmd(CMD_EXIT);
                endcase
                queued += 2;
            end else if (pick < 51) begin
                queue_cmd(CMD_BL_ON);
                rx_backlog.push_back(8'($urandom_range(0, 255)));
                queued += 3;
            end else if (pick < 66) begin
                queue_cmd(CMD_POSITION);
                // usually a sensible column and row, sometimes anything
                rx_backlog.push_back(($urandom_range(0, 4) == 0) ?
                                     8'($urandom_range(0, 255)) : 8'($urandom_range(0, 40)));
                rx_backlog.push_back(($urandom_range(0, 4) == 0) ?
                                     8'($urandom_range(0, 255)) : 8'($urandom_range(0, 4)));
                queued += 4;
            end else if (pick < 71) begin
                queue_cmd(CMD_BRIGHTNESS);
                rx_backlog.push_back(8'($urandom_range(0, 255)));
                queued += 3;
            end else if (pick < 79) begin
                queue_cmd(CMD_CUSTOM);
                repeat (CG_BYTES) rx_backlog.push_back(8'($urandom_range(0, 255)));
                queued += 2 + CG_BYTES;
            end else if (pick < 83) begin
                queue_cmd(CMD_NET_INFO);
                queued += 2;
            end else if (pick < 90) begin
                queue_cmd(8'($urandom_range(0, 255)));
                queued += 2;
            end else begin
                // raw noise, escape byte included
                n = $urandom_range(1, 4);
                repeat (n) rx_backlog.push_back(8'($urandom_range(0, 255)));
                queued += n;
            end
        end
    endtask

    // Wait until every byte is taken and every display op has come out
    task automatic wait_quiet();
        do begin
            @(posedge aclk);
        end while (rx_backlog.size() != 0 || s_tvalid || pending_display_ops.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [5:0] stride);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= stride;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        row_stride  = stride;
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_quiet();
    endtask

    // Stimulus sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: text extremes, every command, special cases
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        queue_cmd(CMD_BL_ON);
        rx_backlog.push_back(8'hA5);
        queue_cmd(CMD_BL_OFF);
        queue_cmd(CMD_CLEAR);
        queue_cmd(CMD_HOME);
        queue_cmd(CMD_UL_ON);
        queue_cmd(CMD_UL_OFF);
        queue_cmd(CMD_BLINK_ON);
        queue_cmd(CMD_BLINK_OFF);
        // cursor address 1 raises the stop request
        queue_cmd(CMD_POSITION);
        rx_backlog.push_back(8'd1);
        rx_backlog.push_back(8'd1);
        // row zero wraps
        queue_cmd(CMD_POSITION);
        rx_backlog.push_back(8'd255);
        rx_backlog.push_back(8'd0);
        queue_cmd(CMD_BRIGHTNESS);
        rx_backlog.push_back(8'hFF);
        // escape byte inside the bitmap is plain data
        queue_cmd(CMD_CUSTOM);
        rx_backlog.push_back(8'h3F);
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(ESC_BYTE);
        rx_backlog.push_back(8'h15);
        rx_backlog.push_back(8'h0A);
        rx_backlog.push_back(8'h1F);
        rx_backlog.push_back(8'h11);
        rx_backlog.push_back(8'h0E);
        queue_cmd(CMD_NET_INFO);
        queue_cmd(CMD_EXIT);
        queue_cmd(CMD_UNDEFINED);
        queue_cmd(ESC_BYTE);
        rx_backlog.push_back(8'h5A);
        queue_random_traffic(RANDOM_PER_PHASE);
        wait_quiet();

        // stride settings, extremes and out of range included
        run_phase(6'd1);
        run_phase(6'd40);
        run_phase(6'd0);
        run_phase(6'd63);
        run_phase(6'($urandom_range(0, 63)));

        if (mismatches == 0 && pending_display_ops.size() == 0) begin
            $display("** lcd_command_stream_parser: PASSED **");
        end else begin
            $display("** lcd_command_stream_parser: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("** lcd_command_stream_parser: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/lcsp_pkg.sv
rtl/lcsp_ctrl.sv
rtl/lcsp_datapath.sv
rtl/lcd_command_stream_parser.sv
rtl/lcsp_checker.sv
dv/lcd_command_stream_parser_test.sv
